/* rtl/cia_pkg.sv */
`default_nettype none
package cia_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 4;
  localparam int unsigned NumCells  = DataWidth;

  typedef enum logic [OpWidth-1:0] {
    OP_LT  = 4'd0,
    OP_GT  = 4'd1,
    OP_LE  = 4'd2,
    OP_GE  = 4'd3,
    OP_EQ  = 4'd4,
    OP_NE  = 4'd5,
    OP_ADD = 4'd6,
    OP_SUB = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9,
    OP_MOD = 4'd10,
    OP_AND = 4'd11,
    OP_OR  = 4'd12,
    OP_NOT = 4'd13,
    OP_NEG = 4'd14,
    OP_NOP = 4'd15
  } op_e;

  // Work carried down the divider row, one restoring step per cell.
  typedef struct packed {
    logic                 vld;
    logic                 last;
    op_e                  op;
    logic                 neg_q;     // quotient sign
    logic                 neg_r;     // remainder sign (sign of first)
    logic                 div_zero;
    logic [DataWidth-1:0] rem;       // partial remainder
    logic [DataWidth-1:0] quo;       // dividend shifting out, quotient in
    logic [DataWidth-1:0] dvs;       // divisor magnitude
    logic [DataWidth-1:0] alt;       // result of non-divide ops
  } cia_work_t;

endpackage
`default_nettype wire

/* rtl/cia_cell.sv */
`default_nettype none
// One restoring divide step; the non-divide result rides along.
module cia_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  cia_pkg::cia_work_t      work_i,
  output cia_pkg::cia_work_t      work_o
);

  cia_pkg::cia_work_t work_d, work_q;
  logic [cia_pkg::DataWidth:0] shifted;
  logic [cia_pkg::DataWidth:0] trial;

  always_comb begin
    shifted = {work_i.rem, work_i.quo[cia_pkg::DataWidth-1]};
    trial   = shifted - {1'b0, work_i.dvs};
    work_d  = work_i;
    if (!trial[cia_pkg::DataWidth]) begin
      work_d.rem = trial[cia_pkg::DataWidth-1:0];
      work_d.quo = {work_i.quo[cia_pkg::DataWidth-2:0], 1'b1};
    end else begin
      work_d.rem = shifted[cia_pkg::DataWidth-1:0];
      work_d.quo = {work_i.quo[cia_pkg::DataWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
    end else if (en_i) begin
      work_q <= work_d;
    end
  end

  assign work_o = work_q;

endmodule
`default_nettype wire

/* rtl/cia_front.sv */
`default_nettype none
// Entry stage: decodes the item, computes all non-divide ops including the
// multiply, and prepares operand magnitudes for the divider row.
module cia_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            vld_i,
  input  wire logic [cia_pkg::OpWidth-1:0]     op_i,
  input  wire logic [cia_pkg::DataWidth-1:0]   first_i,
  input  wire logic [cia_pkg::DataWidth-1:0]   second_i,
  input  wire logic                            last_i,
  output cia_pkg::cia_work_t                   work_o
);

  localparam int unsigned W = cia_pkg::DataWidth;

  cia_pkg::cia_work_t work_d, work_q;
  cia_pkg::op_e       op;
  logic signed [W-1:0] a_s, b_s;
  logic               lt, gt, eq, a_nz, b_nz;
  logic [W-1:0]       one;

  always_comb begin
    op    = cia_pkg::op_e'(op_i);
    a_s   = first_i;
    b_s   = second_i;
    lt    = a_s < b_s;
    gt    = b_s < a_s;
    eq    = first_i == second_i;
    a_nz  = |first_i;
    b_nz  = |second_i;
    one   = {{(W-1){1'b0}}, 1'b1};

    work_d          = '0;
    work_d.vld      = vld_i;
    work_d.last     = last_i;
    work_d.op       = op;
    work_d.neg_r    = first_i[W-1];
    work_d.neg_q    = first_i[W-1] ^ second_i[W-1];
    work_d.div_zero = ~b_nz;
    work_d.rem      = '0;
    work_d.quo      = first_i[W-1] ? (W'(0) - first_i) : first_i;
    work_d.dvs      = second_i[W-1] ? (W'(0) - second_i) : second_i;

    unique case (op)
      cia_pkg::OP_LT:  work_d.alt = lt ? one : '0;
      cia_pkg::OP_GT:  work_d.alt = gt ? one : '0;
      cia_pkg::OP_LE:  work_d.alt = gt ? '0 : one;
      cia_pkg::OP_GE:  work_d.alt = lt ? '0 : one;
      cia_pkg::OP_EQ:  work_d.alt = eq ? one : '0;
      cia_pkg::OP_NE:  work_d.alt = eq ? '0 : one;
      cia_pkg::OP_ADD: work_d.alt = first_i + second_i;
      cia_pkg::OP_SUB: work_d.alt = first_i - second_i;
      cia_pkg::OP_MUL: work_d.alt = W'(first_i * second_i);
      cia_pkg::OP_AND: work_d.alt = (a_nz && b_nz) ? one : '0;
      cia_pkg::OP_OR:  work_d.alt = (a_nz || b_nz) ? one : '0;
      cia_pkg::OP_NOT: work_d.alt = a_nz ? '0 : one;
      cia_pkg::OP_NEG: work_d.alt = W'(0) - first_i;
      default:         work_d.alt = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
    end else if (en_i) begin
      work_q <= work_d;
    end
  end

  assign work_o = work_q;

endmodule
`default_nettype wire

/* rtl/column_integer_alu.sv */
`default_nettype none
// column_integer_alu: element-wise integer operator for column pages.
// Input channel s_axis: tdata carries op, first, second; tlast marks the
// final element of a page. Output channel m_axis: tdata carries result,
// tlast copies the input mark. One result leaves for every item taken,
// in order.
// Every item passes the entry stage register, the row of restoring divide
// cells (one quotient bit per cell) and the output register, the same
// path for every opcode.
// Throughput: one item per cycle. The whole row advances together; it
// stalls only when the output register is full and not taken, and
// s_axis_tready falls in that case only.
// Reset clears all valid flags; nothing else needs clearing.
// When the receiver holds m_axis_tready low, the result stays on the
// port unchanged and the row and input stall behind it.
// The multiply is one 32x32 product in the entry stage.
module column_integer_alu (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // [3:0] op, [35:4] first, [67:36] second, [71:68] zero fill
  input  wire logic [71:0]  s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] result
  output      logic [31:0]  m_axis_tdata,
  output      logic         m_axis_tlast
);

  localparam int unsigned W = cia_pkg::DataWidth;
  localparam int unsigned N = cia_pkg::NumCells;

  logic               adv;
  cia_pkg::cia_work_t row [N+1];
  logic [W-1:0]       res_d, res_q;
  logic               last_q, vld_q;
  cia_pkg::cia_work_t tail;

  // The row moves whenever the output slot is empty or being emptied.
  assign adv           = !vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  cia_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (s_axis_tvalid),
    .op_i     (s_axis_tdata[3:0]),
    .first_i  (s_axis_tdata[35:4]),
    .second_i (s_axis_tdata[67:36]),
    .last_i   (s_axis_tlast),
    .work_o   (row[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    cia_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .work_i (row[g]),
      .work_o (row[g+1])
    );
  end

  assign tail = row[N];

  // Sign fix-up and op select at the end of the row.
  always_comb begin
    if (tail.op == cia_pkg::OP_DIV) begin
      if (tail.div_zero) res_d = '0;
      else               res_d = tail.neg_q ? (W'(0) - tail.quo) : tail.quo;
    end else if (tail.op == cia_pkg::OP_MOD) begin
      if (tail.div_zero) res_d = '0;
      else               res_d = tail.neg_r ? (W'(0) - tail.rem) : tail.rem;
    end else begin
      res_d = tail.alt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= tail.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_d;
      last_q <= tail.last;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = last_q;

  // A stalled result must not be replaced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("result changed while stalled");

  // Input is refused only while the output slot holds an untaken result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without output stall");

  // A divide that reaches the end with a zero divisor gives zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && tail.vld && tail.div_zero &&
    (tail.op == cia_pkg::OP_DIV || tail.op == cia_pkg::OP_MOD)
    |=> m_axis_tdata == '0)
    else $error("zero divisor gave nonzero result");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  // One expected element result: value and end-of-page mark.
  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } elem_res_t;

  // Scoreboard: predicts each accepted element and checks results in order.
  class alu_scoreboard;
    elem_res_t pending_q[$];
    int unsigned mismatches;

    function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b, bit want_rem);
      logic [31:0] ma, mb, q, r;
      if (b == 0) return 32'd0;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      r = ma % mb;
      if (want_rem) return a[31] ? -r : r;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] eval_op(cia_pkg::op_e op, logic [31:0] a,
                                            logic [31:0] b);
      case (op)
        cia_pkg::OP_LT:  return {31'd0, $signed(a) < $signed(b)};
        cia_pkg::OP_GT:  return {31'd0, $signed(a) > $signed(b)};
        cia_pkg::OP_LE:  return {31'd0, $signed(a) <= $signed(b)};
        cia_pkg::OP_GE:  return {31'd0, $signed(a) >= $signed(b)};
        cia_pkg::OP_EQ:  return {31'd0, a == b};
        cia_pkg::OP_NE:  return {31'd0, a != b};
        cia_pkg::OP_ADD: return a + b;
        cia_pkg::OP_SUB: return a - b;
        cia_pkg::OP_MUL: return a * b;
        cia_pkg::OP_DIV: return div_trunc(a, b, 1'b0);
        cia_pkg::OP_MOD: return div_trunc(a, b, 1'b1);
        cia_pkg::OP_AND: return {31'd0, (a != 0) && (b != 0)};
        cia_pkg::OP_OR:  return {31'd0, (a != 0) || (b != 0)};
        cia_pkg::OP_NOT: return {31'd0, a == 0};
        cia_pkg::OP_NEG: return -a;
        default: return 32'd0;
      endcase
    endfunction

    function void note_element(cia_pkg::op_e op, logic [31:0] a, logic [31:0] b,
                               logic last);
      elem_res_t e;
      e.value = eval_op(op, a, b);
      e.last  = last;
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [31:0] value, logic last);
      elem_res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h last %b", value, last);
        return;
      end
      e = pending_q.pop_front();
      if (e.value !== value || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%b got %h/%b", e.value, e.last, value, last);
      end
    endfunction
  endclass

  localparam int unsigned Latency    = cia_pkg::DataWidth + 2;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 425;
  localparam int unsigned HoldLen    = 120;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  alu_scoreboard col_sb;
  int unsigned   send_idle_pct;   // sender idle chance per cycle, percent
  int unsigned   recv_idle_pct;   // receiver stall chance per cycle, percent
  logic          hold_go = 1'b0;  // request for one long receiver hold-off
  logic          hold_used = 1'b0;
  int unsigned   hold_cycles;     // forced receiver hold-off, counted down
  int unsigned   cycle_cnt;

  column_integer_alu i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: ends a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or one long forced hold-off once requested.
  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used     <= 1'b1;
      hold_cycles   <= HoldLen;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output monitor; sampled at the edge, inputs change only via NBA.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      col_sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Offer one element and wait for its acceptance, with random idle gaps.
  // tvalid stays high after acceptance until an idle gap in the next call or stop_input drops it.
  task automatic send_element(cia_pkg::op_e op, logic [31:0] a, logic [31:0] b,
                              logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, b, a, op};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    col_sb.note_element(op, a, b, last);
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // Operand pool leaning on the edges: zero, +-1, extremes, small, full random.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(15) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (col_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0]  a, b;
    cia_pkg::op_e op;
    col_sb        = new();
    send_idle_pct = 9;
    recv_idle_pct = 72;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every opcode, divide by zero, most negative over minus one,
    // remainder sign, nonzero-as-true, unused opcode, full-width operands.
    for (int k = 0; k < 16; k++)
      send_element(cia_pkg::op_e'(k), 32'h8000_0000, 32'h7FFF_FFFF, k[0]);
    send_element(cia_pkg::OP_DIV, 32'd7, 32'd0, 1'b0);
    send_element(cia_pkg::OP_MOD, 32'hFFFF_FFF9, 32'd0, 1'b0);
    send_element(cia_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_element(cia_pkg::OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_element(cia_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2, 1'b0);
    send_element(cia_pkg::OP_MOD, 32'hFFFF_FFF9, 32'd2, 1'b0);
    send_element(cia_pkg::OP_MOD, 32'd7, 32'hFFFF_FFFE, 1'b0);
    send_element(cia_pkg::OP_AND, 32'h8000_0000, 32'd2, 1'b0);
    send_element(cia_pkg::OP_OR, 32'd0, 32'd0, 1'b1);
    stop_input();

    // Sender pauses until every result is back.
    wait_drained();

    // Random part in three idle profiles.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 9;
      end
      if (n == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b1;   // long stall: pipeline fills, input backs up
      end
      op = cia_pkg::op_e'($urandom_range(15));
      a  = pick_operand();
      b  = ($urandom_range(7) == 0) ? a : pick_operand();
      send_element(op, a, b, ($urandom_range(7) == 0));
    end
    stop_input();

    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    if (col_sb.mismatches == 0 && col_sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* column_integer_alu.f */
rtl/cia_pkg.sv
rtl/cia_cell.sv
rtl/cia_front.sv
rtl/column_integer_alu.sv
tb/tb_top.sv
